// ----- sv/sorted_id_set_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted ID set filter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_SET_FILTER_DEFINES_SVH
`define SORTED_ID_SET_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SISF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SISF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sisf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted ID set filter package
// Sizes, action codes and transaction payload types shared by the design.
// ----------------------------------------------------------------------------
package sisf_pkg;

    localparam int TABLE_CAPACITY = 64;
    localparam int ADDR_W   = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
    localparam int CNT_W    = $clog2(TABLE_CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int INDEX_W  = 7;
    localparam int OUT_CNT_W = 7;
    localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [1:0] {
        ACT_REPLACE = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_QUERY   = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [ID_W-1:0]      erd_value;
        logic                 last_of_batch;
        logic [INDEX_W-1:0]   entry_index;
    } req_t;

    typedef struct packed {
        logic                 is_member;
        logic [ID_W-1:0]      entry_value;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 filter_active;
    } rsp_t;

endpackage

// ----- sv/sisf_req_if.sv -----
// ----------------------------------------------------------------------------
// Sorted ID set filter request channel
// Valid/ready channel that carries one request transaction.
// ----------------------------------------------------------------------------
interface sisf_req_if
    import sisf_pkg::*;
;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sisf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Sorted ID set filter response channel
// Valid/ready channel that carries one response transaction.
// ----------------------------------------------------------------------------
interface sisf_rsp_if
    import sisf_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sisf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sisf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/sorted_id_set_filter.sv -----
// ----------------------------------------------------------------------------
// Sorted ID set filter
// Up to TABLE_CAPACITY 16-bit identifiers held in ascending order in a single
// table memory, used as a pass filter. One request gives one response.
// ----------------------------------------------------------------------------
// The block handles one request at a time and drops ready until its response
// is loaded into the output register. All work goes through the table RAM,
// which has one write and one registered read port, under a small sequencer
// with one shared comparator. A membership query or an append runs a linear
// scan over the entries held and then loads the response, stopping early when
// the scan hits; an append that inserts then shifts larger entries up one slot
// at a time; a replace item shifts and places without a scan; an index read
// issues the read, takes the data and then loads the response. A disabled-filter
// query, a dropped append, a dropped replace item and an out-of-range read go
// straight to the response load. Each of these takes longer while the previous
// response still waits in the output register. The table needs no clearing
// after reset; requests are accepted from the first cycle.
`include "sorted_id_set_filter_defines.svh"

module sorted_id_set_filter
    import sisf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    sisf_req_if.sink   req,
    sisf_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_START,
        ST_SHIFT,
        ST_PLACE,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_RESP
    } state_t;

    state_t            state_reg,     state_next;
    action_t           act_reg,       act_next;
    logic [ID_W-1:0]   val_reg,       val_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic [CNT_W-1:0]  pos_reg,       pos_next;
    logic              chk_reg,       chk_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic              filt_reg,      filt_next;
    logic              open_reg,      open_next;
    logic              member_reg,    member_next;
    logic [ID_W-1:0]   entry_reg,     entry_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg,  rsp_data_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ID_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_W-1:0]   ram_rdata;

    logic              cmp_eq;
    logic              cmp_gt;
    logic              hit;
    logic [CNT_W-1:0]  cnt_eff;

    sisf_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared comparator: equality during the scan, ordering during the shift.
    assign cmp_eq = (ram_rdata == val_reg);
    assign cmp_gt = (ram_rdata > val_reg);
    assign hit    = chk_reg && cmp_eq;

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        chk_next       = chk_reg;
        count_next     = count_reg;
        filt_next      = filt_reg;
        open_next      = open_reg;
        member_next    = member_reg;
        entry_next     = entry_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(pos_reg);
        ram_wdata      = val_reg;
        ram_raddr      = ADDR_W'(idx_reg);
        cnt_eff        = open_reg ? count_reg : '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = req.payload.action;
                    val_next    = req.payload.erd_value;
                    idx_next    = '0;
                    chk_next    = 1'b0;
                    member_next = 1'b0;
                    entry_next  = '0;
                    case (req.payload.action)
                        ACT_REPLACE:
                        begin
                            // The first item of a batch starts from an empty table.
                            filt_next  = 1'b1;
                            open_next  = !req.payload.last_of_batch;
                            count_next = cnt_eff;
                            if (CMP_W'(cnt_eff) >= CMP_W'(TABLE_CAPACITY))
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_SHIFT_START;
                            end
                        end
                        ACT_APPEND:
                        begin
                            if (!filt_reg || (CMP_W'(count_reg) >= CMP_W'(TABLE_CAPACITY)))
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (!filt_reg)
                            begin
                                member_next = 1'b1;
                                state_next  = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            if (CMP_W'(req.payload.entry_index) < CMP_W'(count_reg))
                            begin
                                idx_next   = CNT_W'(req.payload.entry_index);
                                state_next = ST_RD_ISSUE;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Each read is compared in the cycle after it is issued.
                if (idx_reg < count_reg)
                begin
                    ram_raddr = ADDR_W'(idx_reg);
                    idx_next  = idx_reg + CNT_W'(1);
                    chk_next  = 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                end
                if (hit || (idx_reg >= count_reg))
                begin
                    if (act_reg == ACT_QUERY)
                    begin
                        member_next = hit;
                        state_next  = ST_RESP;
                    end
                    else if (hit)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_START;
                    end
                end
            end

            ST_SHIFT_START:
            begin
                pos_next = count_reg;
                if (count_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // The read data is the entry just below the open slot.
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - CNT_W'(1);
                    if (pos_reg == CNT_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        ram_raddr = ADDR_W'(pos_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_RESP;
                end
            end

            ST_PLACE:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_RESP;
            end

            ST_RD_ISSUE:
            begin
                ram_raddr  = ADDR_W'(idx_reg);
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                entry_next = ram_rdata;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.is_member     = member_reg;
                    rsp_data_next.entry_value   = entry_reg;
                    rsp_data_next.entry_count   = OUT_CNT_W'(count_reg);
                    rsp_data_next.filter_active = filt_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            filt_reg      <= 1'b0;
            open_reg      <= 1'b0;
            chk_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            filt_reg      <= filt_next;
            open_reg      <= open_next;
            chk_reg       <= chk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        member_reg   <= member_next;
        entry_reg    <= entry_next;
        rsp_data_reg <= rsp_data_next;
    end

    `SISF_ASSERT_SAME(a_count_in_range, 1'b1,
        CMP_W'(count_reg) <= CMP_W'(TABLE_CAPACITY), "entry count exceeds capacity")
    `SISF_ASSERT_SAME(a_shift_slot, state_reg == ST_SHIFT,
        pos_reg != '0, "shift step with no entry below the open slot")
    `SISF_ASSERT_NEXT(a_accept_busy, req.valid && req.ready,
        state_reg != ST_IDLE, "accepted transaction left the sequencer idle")
    `SISF_ASSERT_SAME(a_count_step, count_reg != $past(count_reg),
        (count_reg == $past(count_reg) + CNT_W'(1)) || (count_reg == '0),
        "entry count changed by more than one insert")

endmodule
